### hdl/fsjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjd_pkg
// Types and fixed constants shared by the job dispatcher modules.
// ----------------------------------------------------------------------------
package fsjd_pkg;

  localparam int unsigned JOB_W       = 8;
  localparam int unsigned LEN_W       = 12;
  localparam int unsigned OUT_TIME_W  = 16;
  localparam int unsigned WT_W        = 24;
  localparam int unsigned QFRAC_W     = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned FRONT_DEPTH = 2;
  localparam int unsigned FRONT_PTR_W = 1;
  localparam int unsigned FRONT_CNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd1;

  localparam logic [WT_W-1:0] WT_MAX = '1;

  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_ARRIVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_DISPATCH = 2'd1,
    STAT_ACCEPT   = 2'd2,
    STAT_DROP     = 2'd3
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [JOB_W-1:0]  job_id;
    logic [LEN_W-1:0]  run_length;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    status_e               status;
    logic [JOB_W-1:0]      out_job;
    logic [OUT_TIME_W-1:0] start_at;
    logic [OUT_TIME_W-1:0] wait_ticks;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [WT_W-1:0]       weighted_turnaround_q8;
  } result_t;

endpackage
`default_nettype wire

### hdl/fsjd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fsjd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hdl/fsjd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjd_front
// Input side: takes items, tags them as tick or arrival and holds them in a
// two-entry queue in front of the dispatch engine.
// ----------------------------------------------------------------------------
module fsjd_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      action_i,
  input  wire logic [fsjd_pkg::JOB_W-1:0] job_id_i,
  input  wire logic [fsjd_pkg::LEN_W-1:0] run_length_i,
  output fsjd_pkg::item_t                item_o,
  output logic                           item_valid_o,
  input  wire logic                      item_take_i
);
  import fsjd_pkg::*;

  item_t                  fifo_q [FRONT_DEPTH];
  logic [FRONT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FRONT_CNT_W-1:0] cnt_q;
  logic                   wr_en, rd_en;
  item_t                  in_item;

  assign full         = (cnt_q == FRONT_CNT_W'(FRONT_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign wr_en        = push && !full;
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = fifo_q[rd_ptr_q];

  always_comb begin
    in_item.kind       = kind_e'(action_i);
    in_item.job_id     = job_id_i;
    in_item.run_length = run_length_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + FRONT_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + FRONT_PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + FRONT_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FRONT_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule
`default_nettype wire

### hdl/fsjd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjd_div
// Restoring divider, one quotient bit per cycle, quotient saturated to the
// weighted turnaround width.
// ----------------------------------------------------------------------------
module fsjd_div #(
  parameter int unsigned DVD_W = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [DVD_W-1:0]           dividend_i,
  input  wire logic [fsjd_pkg::LEN_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [fsjd_pkg::WT_W-1:0]       quotient_o
);
  import fsjd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam int unsigned QX_W  = (DVD_W > WT_W) ? DVD_W : WT_W;

  logic [LEN_W-1:0] rem_q;
  logic [LEN_W-1:0] dsr_q;
  logic [DVD_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [LEN_W:0]   rem_sh, rem_nx;
  logic             ge;
  logic [QX_W-1:0]  q_ext;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

  assign q_ext      = QX_W'(quo_q);
  assign quotient_o = (q_ext > QX_W'(WT_MAX)) ? WT_MAX : WT_W'(q_ext);
  assign done_o     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      quo_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= LEN_W'(rem_nx);
      quo_q <= {quo_q[DVD_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/fsjd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjd_back
// Dispatch engine: waiting table in RAM, arrival append, FCFS/SJF scan,
// entry removal by copy-down sweep, divider for weighted turnaround and the
// result register.
// ----------------------------------------------------------------------------
module fsjd_back #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fsjd_pkg::cfg_t    cfg_i,
  input  wire fsjd_pkg::item_t   item_i,
  input  wire logic              item_valid_i,
  output logic                   item_take_o,
  input  wire logic              res_pop_i,
  output fsjd_pkg::result_t      res_o,
  output logic                   res_valid_o
);
  import fsjd_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = JOB_W + LEN_W + TIME_BITS;
  localparam int unsigned SUM_W = ((TIME_BITS > LEN_W) ? TIME_BITS : LEN_W) + 1;
  localparam int unsigned DVD_W = TIME_BITS + QFRAC_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SHIFT,
    ST_DIV
  } state_e;

  state_e               state_q;
  logic                 policy_q;
  logic [TIME_BITS-1:0] cur_q, busy_q;
  logic [CNT_W-1:0]     count_q, rd_idx_q, cmp_idx_q, lim_q;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [JOB_W-1:0]     best_id_q;
  logic [LEN_W-1:0]     best_len_q;
  logic [TIME_BITS-1:0] best_arr_q, wait_q, turn_q;
  result_t              res_q;
  logic                 res_vld_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;
  logic [JOB_W-1:0]     rd_id;
  logic [LEN_W-1:0]     rd_len;
  logic [TIME_BITS-1:0] rd_arr;
  logic [CNT_W-1:0]     shift_dst;
  logic                 issue, room, srv_free, future_job, div_start, div_done;
  logic [TIME_BITS-1:0] wait_c, turn_c, busy_c, cur_inc;
  logic [SUM_W-1:0]     turn_sum, busy_sum;
  logic [WT_W-1:0]      div_quo;

  assign rd_id  = ram_rdata[ENT_W-1 -: JOB_W];
  assign rd_len = ram_rdata[TIME_BITS +: LEN_W];
  assign rd_arr = ram_rdata[TIME_BITS-1:0];

  assign item_take_o = (state_q == ST_IDLE) && item_valid_i && !res_vld_q;
  assign room        = (count_q < CNT_W'(QUEUE_DEPTH));
  assign srv_free    = (cur_q >= busy_q) && (count_q != '0);
  assign future_job  = (best_arr_q > cur_q);
  assign issue       = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_idx_q < lim_q);
  assign shift_dst   = cmp_idx_q - CNT_W'(1);

  assign wait_c   = cur_q - best_arr_q;
  assign turn_sum = SUM_W'(wait_c) + SUM_W'(best_len_q);
  assign turn_c   = (turn_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(turn_sum);
  assign busy_sum = SUM_W'(cur_q) + SUM_W'(best_len_q);
  assign busy_c   = (busy_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(busy_sum);
  assign cur_inc  = (cur_q == TIME_MAX) ? cur_q : cur_q + TIME_BITS'(1);

  assign div_start = (state_q == ST_CHECK) && !future_job;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[IDX_W-1:0];
    ram_wdata = {item_i.job_id, item_i.run_length, cur_q};
    if (item_take_o && (item_i.kind == KIND_ARRIVE) && room) begin
      ram_we = 1'b1;
    end else if ((state_q == ST_SHIFT) && rd_vld_q) begin
      ram_we    = 1'b1;
      ram_waddr = shift_dst[IDX_W-1:0];
      ram_wdata = ram_rdata;
    end
  end

  fsjd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  fsjd_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({turn_c, QFRAC_W'(0)}),
    .divisor_i  (best_len_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      policy_q   <= 1'b0;
      cur_q      <= '0;
      busy_q     <= '0;
      count_q    <= '0;
      rd_idx_q   <= '0;
      cmp_idx_q  <= '0;
      lim_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_idx_q <= '0;
      best_id_q  <= '0;
      best_len_q <= '0;
      best_arr_q <= '0;
      wait_q     <= '0;
      turn_q     <= '0;
      res_q      <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      if (res_pop_i && res_vld_q) begin
        res_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (item_take_o) begin
            if (item_i.kind == KIND_ARRIVE) begin
              res_q     <= '{status: (room ? STAT_ACCEPT : STAT_DROP), default: '0};
              res_vld_q <= 1'b1;
              if (room) begin
                count_q <= count_q + CNT_W'(1);
              end
            end else if (srv_free) begin
              state_q  <= ST_SCAN;
              rd_idx_q <= '0;
              rd_vld_q <= 1'b0;
              lim_q    <= policy_q ? count_q : CNT_W'(1);
            end else begin
              res_q     <= '0;
              res_vld_q <= 1'b1;
              cur_q     <= cur_inc;
            end
          end
        end

        ST_SCAN: begin
          // one read in flight; compare lands in the cycle after its address
          rd_vld_q  <= issue;
          cmp_idx_q <= rd_idx_q;
          if (issue) begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
          if (rd_vld_q && ((cmp_idx_q == '0) || (rd_len < best_len_q))) begin
            best_idx_q <= cmp_idx_q[IDX_W-1:0];
            best_id_q  <= rd_id;
            best_len_q <= rd_len;
            best_arr_q <= rd_arr;
          end
          if (!issue && !rd_vld_q) begin
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (future_job) begin
            res_q     <= '0;
            res_vld_q <= 1'b1;
            cur_q     <= cur_inc;
            state_q   <= ST_IDLE;
          end else begin
            wait_q   <= wait_c;
            turn_q   <= turn_c;
            busy_q   <= busy_c;
            rd_idx_q <= CNT_W'(best_idx_q) + CNT_W'(1);
            rd_vld_q <= 1'b0;
            lim_q    <= count_q;
            state_q  <= ST_SHIFT;
          end
        end

        ST_SHIFT: begin
          // copy entries above the chosen one down by one slot
          rd_vld_q  <= issue;
          cmp_idx_q <= rd_idx_q;
          if (issue) begin
            rd_idx_q <= rd_idx_q + CNT_W'(1);
          end
          if (!issue && !rd_vld_q) begin
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_done) begin
            res_q.status     <= STAT_DISPATCH;
            res_q.out_job    <= best_id_q;
            res_q.start_at   <= OUT_TIME_W'(cur_q);
            res_q.wait_ticks <= OUT_TIME_W'(wait_q);
            res_q.turnaround <= OUT_TIME_W'(turn_q);
            res_q.weighted_turnaround_q8 <= (best_len_q == '0) ? WT_MAX : div_quo;
            res_vld_q <= 1'b1;
            count_q   <= count_q - CNT_W'(1);
            cur_q     <= cur_inc;
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_POLICY:     policy_q <= cfg_i.data[0];
          REG_START_TIME: cur_q    <= TIME_BITS'(cfg_i.data);
          default:        ;
        endcase
      end
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_vld_q;

endmodule
`default_nettype wire

### hdl/fcfs_sjf_job_dispatcher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcfs_sjf_job_dispatcher_core
// Non-preemptive single-server job dispatcher, FCFS or SJF selection.
//
//   channel  | direction | handshake          | beat
//   ---------+-----------+--------------------+-------------------------------
//   input    | in        | push / full        | action, job_id, run_length
//   result   | out       | empty / pop        | status, job, times, wt Q8
//   config   | in        | cfg_valid / ready  | register index, write data
//
// An arrival is handled in the engine's idle state after the 2-entry queue.
// A tick with nothing to dispatch is also handled there. A dispatching tick
// makes S table reads for the scan (1 for FCFS, waiting count for SJF),
// then copies R entries down through the single RAM port while the
// bit-serial weighted turnaround divider runs beside it.
// A tick whose chosen job is stamped after the current time ends in ST_CHECK.
// The engine starts a new item only when the result register is empty.
// Reset clears all control state; the table needs no clearing.
// ----------------------------------------------------------------------------
module fcfs_sjf_job_dispatcher_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            action_i,
  input  wire logic [fsjd_pkg::JOB_W-1:0]      job_id_i,
  input  wire logic [fsjd_pkg::LEN_W-1:0]      run_length_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [1:0]                           status_o,
  output logic [fsjd_pkg::JOB_W-1:0]           out_job_o,
  output logic [fsjd_pkg::OUT_TIME_W-1:0]      start_at_o,
  output logic [fsjd_pkg::OUT_TIME_W-1:0]      wait_ticks_o,
  output logic [fsjd_pkg::OUT_TIME_W-1:0]      turnaround_o,
  output logic [fsjd_pkg::WT_W-1:0]            weighted_turnaround_q8_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fsjd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fsjd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import fsjd_pkg::*;

  item_t   item;
  logic    item_valid, item_take;
  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg.valid = cfg_valid_i;
    cfg.index = cfg_index_i;
    cfg.data  = cfg_wdata_i;
  end

  fsjd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .job_id_i     (job_id_i),
    .run_length_i (run_length_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  fsjd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .res_pop_i    (pop),
    .res_o        (res),
    .res_valid_o  (res_valid)
  );

  assign empty                    = !res_valid;
  assign status_o                 = res.status;
  assign out_job_o                = res.out_job;
  assign start_at_o               = res.start_at;
  assign wait_ticks_o             = res.wait_ticks;
  assign turnaround_o             = res.turnaround;
  assign weighted_turnaround_q8_o = res.weighted_turnaround_q8;

endmodule
`default_nettype wire

### hdl/fsjd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsjd_checker
// Port-level checks for the job dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module fsjd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            push,
  input wire logic                            full,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [1:0]                      status_o,
  input wire logic [fsjd_pkg::JOB_W-1:0]      out_job_o,
  input wire logic [fsjd_pkg::OUT_TIME_W-1:0] start_at_o,
  input wire logic [fsjd_pkg::OUT_TIME_W-1:0] wait_ticks_o,
  input wire logic [fsjd_pkg::OUT_TIME_W-1:0] turnaround_o,
  input wire logic [fsjd_pkg::WT_W-1:0]       weighted_turnaround_q8_o
);
  import fsjd_pkg::*;

  // a waiting result stays put until popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(out_job_o)))
    else $error("result changed before pop");

  // non-dispatch results carry zeroed detail fields
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != STAT_DISPATCH)) |->
      (out_job_o == '0 && start_at_o == '0 && wait_ticks_o == '0 &&
       turnaround_o == '0 && weighted_turnaround_q8_o == '0))
    else $error("detail fields set on non-dispatch result");

  // every dispatched job has a nonzero weighted turnaround
  a_wt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == STAT_DISPATCH)) |-> (weighted_turnaround_q8_o != '0))
    else $error("dispatched job with zero weighted turnaround");

  // input queue fills only after an accepted beat
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // nothing to pop right after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> empty)
    else $error("result present right after reset");

endmodule

bind fcfs_sjf_job_dispatcher_core fsjd_checker u_fsjd_checker (.*);
`default_nettype wire

### sim/fcfs_sjf_job_dispatcher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfs_sjf_job_dispatcher_core_tb
// Self-checking regression for the FCFS / SJF job dispatcher. Directed
// scenarios cover selection order, busy server, zero-length jobs, jobs
// stamped later than the current time, a full table, unused register
// indexes and time saturation. Random traffic then runs under both
// policies with sender gaps and receiver stalls. A scheduler model in the
// bench predicts every result beat, and results are checked in order.
// ----------------------------------------------------------------------------
module fcfs_sjf_job_dispatcher_core_tb;
  import fsjd_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned TIME_CEIL     = 65535;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned DRAIN_LIMIT   = 50_000;
  localparam longint      RUN_LIMIT_NS  = 10_000_000;

  // indexes with no register behind them; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [JOB_W-1:0]      id;
    logic [LEN_W-1:0]      len;
    logic [OUT_TIME_W-1:0] arrival;
  } job_entry_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  push         = 1'b0;
  logic                  full;
  logic                  action_i     = 1'b0;
  logic [JOB_W-1:0]      job_id_i     = '0;
  logic [LEN_W-1:0]      run_length_i = '0;
  logic                  empty;
  logic                  pop          = 1'b0;
  logic [1:0]            status_o;
  logic [JOB_W-1:0]      out_job_o;
  logic [OUT_TIME_W-1:0] start_at_o;
  logic [OUT_TIME_W-1:0] wait_ticks_o;
  logic [OUT_TIME_W-1:0] turnaround_o;
  logic [WT_W-1:0]       weighted_turnaround_q8_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;

  // scheduler model state
  bit          model_sjf  = 1'b0;
  int unsigned model_time = 0;
  int unsigned model_busy = 0;
  job_entry_t  pending_jobs[$];
  result_t     expected_results[$];

  int gap_pct        = 0;
  int stall_pct      = 0;
  int hold_cycles    = 0;
  int mismatch_count = 0;

  fcfs_sjf_job_dispatcher_core #(
    .QUEUE_DEPTH(TABLE_DEPTH),
    .TIME_BITS  (16)
  ) uut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .push                    (push),
    .full                    (full),
    .action_i                (action_i),
    .job_id_i                (job_id_i),
    .run_length_i            (run_length_i),
    .empty                   (empty),
    .pop                     (pop),
    .status_o                (status_o),
    .out_job_o               (out_job_o),
    .start_at_o              (start_at_o),
    .wait_ticks_o            (wait_ticks_o),
    .turnaround_o            (turnaround_o),
    .weighted_turnaround_q8_o(weighted_turnaround_q8_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_wdata_i             (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned time_sat_add(int unsigned a, int unsigned b);
    return (a + b > TIME_CEIL) ? TIME_CEIL : a + b;
  endfunction

  // One input beat through the scheduler model; returns its result beat.
  function automatic result_t dispatch_predict(kind_e kind, logic [JOB_W-1:0] id,
                                               logic [LEN_W-1:0] len);
    result_t     res;
    job_entry_t  job;
    int          pick;
    int unsigned wait_t;
    int unsigned turn;
    res = '0;
    if (kind == KIND_ARRIVE) begin
      if (pending_jobs.size() < TABLE_DEPTH) begin
        job.id      = id;
        job.len     = len;
        job.arrival = OUT_TIME_W'(model_time);
        pending_jobs.push_back(job);
        res.status = STAT_ACCEPT;
      end else begin
        res.status = STAT_DROP;
      end
      return res;
    end
    if (model_time >= model_busy && pending_jobs.size() != 0) begin
      pick = 0;
      // SJF: strict less-than keeps ties on the oldest entry
      if (model_sjf) begin
        for (int i = 1; i < pending_jobs.size(); i++)
          if (pending_jobs[i].len < pending_jobs[pick].len) pick = i;
      end
      job = pending_jobs[pick];
      // a job stamped after the current time stays in the table
      if (job.arrival <= model_time) begin
        wait_t = model_time - job.arrival;
        turn   = time_sat_add(wait_t, job.len);
        res.status     = STAT_DISPATCH;
        res.out_job    = job.id;
        res.start_at   = OUT_TIME_W'(model_time);
        res.wait_ticks = OUT_TIME_W'(wait_t);
        res.turnaround = OUT_TIME_W'(turn);
        res.weighted_turnaround_q8 = (job.len == 0) ? WT_MAX
                                   : WT_W'((turn << QFRAC_W) / job.len);
        model_busy = time_sat_add(model_time, job.len);
        pending_jobs.delete(pick);
      end
    end
    model_time = time_sat_add(model_time, 1);
    return res;
  endfunction

  task automatic send_beat(kind_e kind, logic [JOB_W-1:0] id, logic [LEN_W-1:0] len);
    action_i     <= kind;
    job_id_i     <= id;
    run_length_i <= len;
    push         <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_results.push_back(dispatch_predict(kind, id, len));
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic arrive(logic [JOB_W-1:0] id, logic [LEN_W-1:0] len);
    send_beat(KIND_ARRIVE, id, len);
  endtask

  // job fields carry noise on a tick; the block must ignore them
  task automatic tick();
    send_beat(KIND_TICK, JOB_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_POLICY) model_sjf = data[0];
    else if (idx == REG_START_TIME) model_time = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_empty_tick();
    write_reg(REG_POLICY, 16'hFFFE);
    write_reg(REG_START_TIME, 16'h0000);
    tick();
  endtask

  task automatic test_fcfs_order();
    arrive(8'h00, 12'd2);
    arrive(8'hFF, 12'd0);
    arrive(8'h5A, 12'd1);
    // dispatch, busy, zero-length dispatch, dispatch
    repeat (4) tick();
  endtask

  task automatic test_sjf_ties();
    wait_idle();
    write_reg(REG_POLICY, 16'hFFFF);
    arrive(8'h11, 12'd3);
    arrive(8'h22, 12'd1);
    arrive(8'h33, 12'd1);
    repeat (3) tick();
  endtask

  task automatic test_future_job();
    wait_idle();
    write_reg(REG_POLICY, 16'h0000);
    write_reg(REG_START_TIME, 16'd1000);
    arrive(8'hA5, 12'hFFF);
    wait_idle();
    // move time back below the stamp; FCFS head must stay put
    write_reg(REG_START_TIME, 16'd995);
    repeat (2) tick();
  endtask

  task automatic test_table_full();
    for (int n = 0; n < TABLE_DEPTH; n++) arrive(JOB_W'(n * 17), LEN_W'(n + 1));
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h0001);
    tick();
    arrive(8'h3C, 12'd1);
  endtask

  task automatic test_result_backpressure();
    wait_idle();
    gap_pct     = 0;
    stall_pct   = 0;
    hold_cycles = 300;
    repeat (24) begin
      if ($urandom_range(1)) arrive(JOB_W'($urandom), LEN_W'($urandom_range(0, 4)));
      else tick();
    end
    wait_idle();
  endtask

  task automatic run_random_phase(int beats, int arrive_pct, int sender_gap,
                                  int recv_stall, bit sjf);
    int unsigned      base;
    int unsigned      start;
    int               sel;
    kind_e            kind;
    logic [LEN_W-1:0] len;
    wait_idle();
    gap_pct   = sender_gap;
    stall_pct = recv_stall;
    write_reg(REG_POLICY, {15'($urandom), sjf});
    base = (model_time > model_busy) ? model_time : model_busy;
    sel  = $urandom_range(99);
    // sometimes step back to leave the server busy or jobs in the future
    if (sel < 15 && base >= 20) start = base - $urandom_range(1, 20);
    else if (sel < 30) start = base + $urandom_range(0, 300);
    else start = base;
    if (start > TIME_CEIL) start = TIME_CEIL;
    write_reg(REG_START_TIME, 16'(start));
    for (int n = 0; n < beats; n++) begin
      kind = ($urandom_range(99) < arrive_pct) ? KIND_ARRIVE : KIND_TICK;
      sel  = $urandom_range(99);
      // mostly short jobs so the server keeps turning over
      if (sel < 2) len = LEN_W'($urandom_range(4095));
      else if (sel < 5) len = '0;
      else len = LEN_W'($urandom_range(1, 4));
      send_beat(kind, JOB_W'($urandom), len);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(185, 40,  0,  0, 1'b0);
    run_random_phase(185, 60, 55,  0, 1'b1);
    run_random_phase(185, 60,  0, 55, 1'b0);
    run_random_phase(185, 40,  6,  6, 1'b1);
    run_random_phase(185, 60,  0,  0, 1'b1);
    run_random_phase(185, 40, 55,  0, 1'b0);
    run_random_phase(185, 40,  0, 55, 1'b1);
    run_random_phase(185, 60,  6,  6, 1'b0);
  endtask

  task automatic test_time_saturation();
    wait_idle();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_POLICY, 16'h0000);
    write_reg(REG_START_TIME, 16'hFFFF);
    // at the time ceiling the server is always free: drain the table
    for (int n = 0; n <= TABLE_DEPTH && pending_jobs.size() != 0; n++) tick();
    tick();
    wait_idle();
    write_reg(REG_START_TIME, 16'h0000);
    arrive(8'h7E, 12'd2048);
    arrive(8'h81, 12'd0);
    wait_idle();
    // wait plus length overflows the turnaround
    write_reg(REG_START_TIME, 16'hFFFF);
    repeat (3) tick();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result beat with none expected, status %0d", $time, status_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || out_job_o !== want.out_job ||
            start_at_o !== want.start_at || wait_ticks_o !== want.wait_ticks ||
            turnaround_o !== want.turnaround ||
            weighted_turnaround_q8_o !== want.weighted_turnaround_q8) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp st=%0d job=%0d start=%0d wait=%0d turn=%0d wt=%0d",
                     $time, want.status, want.out_job, want.start_at, want.wait_ticks,
                     want.turnaround, want.weighted_turnaround_q8);
            $display("          act st=%0d job=%0d start=%0d wait=%0d turn=%0d wt=%0d",
                     status_o, out_job_o, start_at_o, wait_ticks_o, turnaround_o,
                     weighted_turnaround_q8_o);
          end
        end
      end
    end
  end

  initial begin : run_tests
    int unsigned waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_tick();
    test_fcfs_order();
    test_sjf_ties();
    test_future_job();
    test_table_full();
    test_unused_index();
    test_result_backpressure();
    test_random_traffic();
    test_time_saturation();
    push   <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("fcfs_sjf_job_dispatcher_core regression: pass");
    else
      $display("fcfs_sjf_job_dispatcher_core regression: fail");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("fcfs_sjf_job_dispatcher_core regression: fail");
    $finish;
  end

endmodule
